// ===== rtl/funnel_quadratic_form_check_macros.svh =====
// Assertion macros for the funnel quadratic form check block.
// Included by the top level, which writes its checks with them.
`ifndef FUNNEL_QUADRATIC_FORM_CHECK_MACROS_SVH
`define FUNNEL_QUADRATIC_FORM_CHECK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FQFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FQFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fqfc_pkg.sv =====
// Shared constants, operation codes and control structs of the funnel
// quadratic form check block. No dependencies.
package fqfc_pkg;

  localparam int STATE_DIM = 8;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = 3;
  localparam int DATA_W  = 32;
  localparam int FORM_W  = 64;
  localparam int NODE_W  = 16;
  localparam int STORE_DEPTH = 2 ** IDX_W;

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [FORM_W-1:0] S64_MAX = {1'b0, {(FORM_W-1){1'b1}}};
  localparam logic signed [FORM_W-1:0] S64_MIN = {1'b1, {(FORM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD_STATE  = 2'd0,
    OP_LOAD_MATRIX = 2'd1,
    OP_EMIT        = 2'd2
  } op_e;

  typedef struct packed {
    logic wr_diff;
    logic rd_mat;
    logic mul1;
    logic mul2;
    logic acc;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

endpackage

// ===== rtl/fqfc_in_if.sv =====
// Input channel of the funnel quadratic form check block.
// Depends on fqfc_pkg for field widths.
interface fqfc_in_if;
  import fqfc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               operation;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0] sample_value;
  logic signed [DATA_W-1:0] nominal_value;
  logic signed [DATA_W-1:0] matrix_value;
  logic signed [FORM_W-1:0] rho_value;
  logic [NODE_W-1:0]        node_index;

  modport source (
    output valid, operation, row_index, col_index, sample_value, nominal_value,
           matrix_value, rho_value, node_index,
    input  ready
  );

  modport sink (
    input  valid, operation, row_index, col_index, sample_value, nominal_value,
           matrix_value, rho_value, node_index,
    output ready
  );
endinterface

// ===== rtl/fqfc_out_if.sv =====
// Result channel of the funnel quadratic form check block.
// Depends on fqfc_pkg for field widths.
interface fqfc_out_if;
  import fqfc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [NODE_W-1:0]        out_node_index;
  logic signed [FORM_W-1:0] form_value;
  logic                     update_flag;
  logic                     saturated;

  modport source (
    output valid, out_node_index, form_value, update_flag, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_node_index, form_value, update_flag, saturated,
    output ready
  );
endinterface

// ===== rtl/fqfc_ctrl.sv =====
// Controller of the funnel quadratic form check block: decodes items and
// sequences the matrix element steps. Depends on fqfc_pkg.
module fqfc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic [1:0]              in_op_i,
  input  logic [fqfc_pkg::IDX_W-1:0] row_i,
  input  logic [fqfc_pkg::IDX_W-1:0] col_i,
  input  fqfc_pkg::dp_status_t    status_i,
  output logic                    in_ready_o,
  output fqfc_pkg::ctrl_cmd_t     cmd_o
);
  import fqfc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_ACC  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  op_e    op;
  logic   accept;
  logic   row_ok;
  logic   col_ok;

  assign op     = op_e'(in_op_i);
  assign row_ok = 32'(row_i) < STATE_DIM;
  assign col_ok = 32'(col_i) < STATE_DIM;

  // An emit also waits while the result register is still held by the sink.
  assign in_ready_o = (state_q == ST_IDLE) && !((op == OP_EMIT) && status_i.out_full);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_LOAD_STATE:  cmd_o.wr_diff = row_ok;
            OP_LOAD_MATRIX: begin
              if (row_ok && col_ok) begin
                cmd_o.rd_mat = 1'b1;
                state_d      = ST_MUL1;
              end
            end
            OP_EMIT:        cmd_o.emit = 1'b1;
            default:        ;
          endcase
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/fqfc_datapath.sv =====
// Datapath of the funnel quadratic form check block: difference store,
// two multiplier stages, saturating accumulator and result register.
// Depends on fqfc_pkg.
module fqfc_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fqfc_pkg::ctrl_cmd_t                cmd_i,
  input  logic [fqfc_pkg::IDX_W-1:0]         row_i,
  input  logic [fqfc_pkg::IDX_W-1:0]         col_i,
  input  logic signed [fqfc_pkg::DATA_W-1:0] sample_i,
  input  logic signed [fqfc_pkg::DATA_W-1:0] nominal_i,
  input  logic signed [fqfc_pkg::DATA_W-1:0] matrix_i,
  input  logic signed [fqfc_pkg::FORM_W-1:0] rho_i,
  input  logic [fqfc_pkg::NODE_W-1:0]        node_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [fqfc_pkg::NODE_W-1:0]        out_node_o,
  output logic signed [fqfc_pkg::FORM_W-1:0] form_o,
  output logic                               update_o,
  output logic                               saturated_o,
  output fqfc_pkg::dp_status_t               status_o
);
  import fqfc_pkg::*;

  localparam int ShiftRight = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
  localparam int ShiftLeft  = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;

  logic signed [DATA_W-1:0] diff_mem [STORE_DEPTH];

  logic signed [DATA_W-1:0] dx_r_q, dx_c_q, mat_q;
  logic signed [FORM_W-1:0] prod1_q, prod2_q;
  logic signed [FORM_W-1:0] acc_q, acc_d;
  logic                     sat_seen_q, sat_seen_d;
  logic                     out_valid_q;
  logic [NODE_W-1:0]        out_node_q;
  logic signed [FORM_W-1:0] form_q;
  logic                     update_q;
  logic                     sat_out_q;

  logic signed [DATA_W:0]   diff_full;
  logic                     diff_sat;
  logic signed [DATA_W-1:0] diff_val;
  logic signed [FORM_W-1:0] prod1;
  logic signed [FORM_W-1:0] shifted1;
  logic                     first_sat;
  logic signed [DATA_W-1:0] first_val;
  logic signed [FORM_W-1:0] prod2;
  logic signed [FORM_W-1:0] scaled_pre;
  logic signed [FORM_W-1:0] scaled_hi;
  logic                     scale_sat;
  logic signed [FORM_W-1:0] scaled;
  logic signed [FORM_W-1:0] sum;
  logic                     add_sat;
  logic signed [FORM_W-1:0] acc_sum;
  logic                     update;

  // Difference, saturated to 32 bits.
  assign diff_full = {sample_i[DATA_W-1], sample_i} - {nominal_i[DATA_W-1], nominal_i};
  assign diff_sat  = diff_full[DATA_W] != diff_full[DATA_W-1];
  assign diff_val  = diff_sat ? (diff_full[DATA_W] ? S32_MIN : S32_MAX)
                              : diff_full[DATA_W-1:0];

  // First product, floor-shifted back to the state format and clamped.
  assign prod1     = dx_r_q * mat_q;
  assign shifted1  = prod1_q >>> FRAC_BITS;
  assign first_sat = (shifted1[FORM_W-1:DATA_W-1] != '0) &&
                     (shifted1[FORM_W-1:DATA_W-1] != '1);
  assign first_val = first_sat ? (shifted1[FORM_W-1] ? S32_MIN : S32_MAX)
                               : shifted1[DATA_W-1:0];
  assign prod2     = first_val * dx_c_q;

  // Second product to 32 fraction bits; the left shift saturates to 64 bits.
  assign scaled_pre = prod2_q >>> ShiftRight;
  assign scaled_hi  = scaled_pre >>> (FORM_W - 1 - ShiftLeft);
  assign scale_sat  = (scaled_hi != '0) && (scaled_hi != '1);
  assign scaled     = scale_sat ? (scaled_pre[FORM_W-1] ? S64_MIN : S64_MAX)
                                : (scaled_pre <<< ShiftLeft);

  assign sum     = acc_q + scaled;
  assign add_sat = (acc_q[FORM_W-1] == scaled[FORM_W-1]) &&
                   (sum[FORM_W-1] != acc_q[FORM_W-1]);
  assign acc_sum = add_sat ? (acc_q[FORM_W-1] ? S64_MIN : S64_MAX) : sum;

  assign update = rho_i > acc_q;

  always_comb begin
    acc_d      = acc_q;
    sat_seen_d = sat_seen_q;
    priority if (cmd_i.emit) begin
      acc_d      = '0;
      sat_seen_d = 1'b0;
    end else if (cmd_i.wr_diff) begin
      sat_seen_d = sat_seen_q | diff_sat;
    end else if (cmd_i.mul2) begin
      sat_seen_d = sat_seen_q | first_sat;
    end else if (cmd_i.acc) begin
      acc_d      = acc_sum;
      sat_seen_d = sat_seen_q | scale_sat | add_sat;
    end
  end

  // Difference store and its registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_diff) begin
      diff_mem[row_i] <= diff_val;
    end
    if (cmd_i.rd_mat) begin
      dx_r_q <= diff_mem[row_i];
      dx_c_q <= diff_mem[col_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_mat) begin
      mat_q <= matrix_i;
    end
    if (cmd_i.mul1) begin
      prod1_q <= prod1;
    end
    if (cmd_i.mul2) begin
      prod2_q <= prod2;
    end
    if (cmd_i.emit) begin
      out_node_q <= node_i;
      form_q     <= update ? acc_q : '0;
      update_q   <= update;
      sat_out_q  <= sat_seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      sat_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      sat_seen_q <= sat_seen_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign form_o      = form_q;
  assign update_o    = update_q;
  assign saturated_o = sat_out_q;

endmodule

// ===== rtl/funnel_quadratic_form_check.sv =====
// Top level of the funnel quadratic form check block: controller plus
// datapath. Depends on fqfc_pkg, fqfc_in_if, fqfc_out_if, fqfc_ctrl,
// fqfc_datapath and the assertion macro header.
//
// Usage: each input item carries an operation. A state load writes
// sample minus nominal into the difference store for one state element.
// A matrix load adds dx[row]*S[row][col]*dx[col] to the form. An emit
// compares rho with the form and produces one result item: the form with
// the update flag set when rho exceeds it, else zero with the flag clear.
// The saturated flag reports any clamp since the previous emit; the emit
// then clears the form and the flag, while the difference store is kept.
// Out-of-range indices and the unused operation code are dropped.
// State loads, emits and dropped items need no further steps after they are
// taken; a matrix load runs through a registered store read, the first
// multiply, the second multiply and the accumulate, during which no item is
// accepted. The result item is valid in the cycle after its emit.
// The result sits in an output register; while the sink stalls, loads
// are still taken and only a further emit waits. Reset clears the form,
// the saturation flag and the result valid flag; the difference store has
// no reset, so each element must be loaded before a matrix load uses it.
`include "funnel_quadratic_form_check_macros.svh"

module funnel_quadratic_form_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  fqfc_in_if.sink    in_i,
  fqfc_out_if.source out_o
);
  import fqfc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fqfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.operation),
    .row_i      (in_i.row_index),
    .col_i      (in_i.col_index),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  fqfc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .row_i       (in_i.row_index),
    .col_i       (in_i.col_index),
    .sample_i    (in_i.sample_value),
    .nominal_i   (in_i.nominal_value),
    .matrix_i    (in_i.matrix_value),
    .rho_i       (in_i.rho_value),
    .node_i      (in_i.node_index),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_node_o  (out_o.out_node_index),
    .form_o      (out_o.form_value),
    .update_o    (out_o.update_flag),
    .saturated_o (out_o.saturated),
    .status_o    (status)
  );

  `FQFC_ASSERT_SAME(a_emit_slot_free, clk_i, rst_ni,
    in_i.valid && in_i.ready && (in_i.operation == OP_EMIT), !status.out_full,
    "emit accepted while the result register is held")
  `FQFC_ASSERT_NEXT(a_emit_gives_result, clk_i, rst_ni,
    cmd.emit, out_o.valid, "emit did not produce a result item")
  `FQFC_ASSERT_NEXT(a_mul1_then_mul2, clk_i, rst_ni,
    cmd.mul1, cmd.mul2 && !in_i.ready, "second multiply did not follow the first")
  `FQFC_ASSERT_SAME(a_one_step, clk_i, rst_ni,
    1'b1, $onehot0({cmd.rd_mat, cmd.mul1, cmd.mul2, cmd.acc}),
    "more than one matrix step issued at once")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for funnel_quadratic_form_check: drives state, matrix and
// emit items, predicts each node's verdict and compares every result item.
// Depends on fqfc_pkg, fqfc_in_if, fqfc_out_if and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fqfc_pkg::*;

  localparam int HALF_PERIOD  = 1;
  localparam int RESET_CYCLES = 5;
  localparam int TOTAL_ITEMS  = 900;
  localparam int TAIL_ITEMS   = 120;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int FORM_FRAC    = 32;

  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] sample_value;
    logic signed [DATA_W-1:0] nominal_value;
    logic signed [DATA_W-1:0] matrix_value;
    logic signed [FORM_W-1:0] rho_value;
    logic [NODE_W-1:0]        node_index;
  } form_op_t;

  typedef struct packed {
    logic [NODE_W-1:0]        node;
    logic signed [FORM_W-1:0] form;
    logic                     upd;
    logic                     sat;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic     op_valid = 1'b0;
  form_op_t op_bus = '0;
  logic     res_ready = 1'b0;
  logic     near_end = 1'b0;

  form_op_t op_queue[$];
  verdict_t expected_verdicts[$];

  // Predicted state of the block.
  logic signed [DATA_W-1:0] dx_store [STORE_DEPTH];
  logic signed [FORM_W-1:0] form_acc = '0;
  logic                     sat_seen = 1'b0;

  int send_gap = 0;
  int stall_left = 0;
  int sink_cycles = 0;
  int cycle_count = 0;
  int mismatches = 0;

  fqfc_in_if  op_if ();
  fqfc_out_if verdict_if ();

  assign op_if.valid         = op_valid;
  assign op_if.operation     = op_bus.operation;
  assign op_if.row_index     = op_bus.row_index;
  assign op_if.col_index     = op_bus.col_index;
  assign op_if.sample_value  = op_bus.sample_value;
  assign op_if.nominal_value = op_bus.nominal_value;
  assign op_if.matrix_value  = op_bus.matrix_value;
  assign op_if.rho_value     = op_bus.rho_value;
  assign op_if.node_index    = op_bus.node_index;
  assign verdict_if.ready    = res_ready;

  funnel_quadratic_form_check DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_if),
    .out_o  (verdict_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  function automatic logic signed [DATA_W-1:0] clamp_to_word(input logic signed [63:0] x);
    if (x > S32_MAX) begin
      sat_seen = 1'b1;
      return S32_MAX;
    end
    if (x < S32_MIN) begin
      sat_seen = 1'b1;
      return S32_MIN;
    end
    return x[DATA_W-1:0];
  endfunction

  function automatic logic signed [FORM_W-1:0] clamp_to_form(input logic signed [127:0] x);
    if (x > S64_MAX) begin
      sat_seen = 1'b1;
      return S64_MAX;
    end
    if (x < S64_MIN) begin
      sat_seen = 1'b1;
      return S64_MIN;
    end
    return x[FORM_W-1:0];
  endfunction

  task automatic advance_form_model(input form_op_t o);
    logic signed [63:0]     lhs;
    logic signed [63:0]     rhs;
    logic signed [63:0]     prod;
    logic signed [63:0]     part;
    logic signed [127:0]    scaled;
    logic signed [DATA_W:0] diff;
    logic signed [FORM_W:0] total;
    verdict_t               v;
    case (o.operation)
      OP_LOAD_STATE: begin
        if (o.row_index < STATE_DIM) begin
          diff = $signed(o.sample_value) - $signed(o.nominal_value);
          dx_store[o.row_index] = clamp_to_word(diff);
        end
      end
      OP_LOAD_MATRIX: begin
        if (o.row_index < STATE_DIM && o.col_index < STATE_DIM) begin
          lhs = dx_store[o.row_index];
          rhs = $signed(o.matrix_value);
          prod = lhs * rhs;
          lhs = clamp_to_word(prod >>> FRAC_BITS);
          rhs = dx_store[o.col_index];
          prod = lhs * rhs;
          // Bring the product from 2*FRAC_BITS fraction bits to the form's 32.
          if (2 * FRAC_BITS > FORM_FRAC) begin
            part = prod >>> (2 * FRAC_BITS - FORM_FRAC);
          end else if (2 * FRAC_BITS < FORM_FRAC) begin
            scaled = prod;
            part = clamp_to_form(scaled <<< (FORM_FRAC - 2 * FRAC_BITS));
          end else begin
            part = prod;
          end
          total = form_acc;
          total = total + part;
          form_acc = clamp_to_form(total);
        end
      end
      OP_EMIT: begin
        v.node = o.node_index;
        v.upd  = $signed(o.rho_value) > form_acc;
        v.form = v.upd ? form_acc : '0;
        v.sat  = sat_seen;
        expected_verdicts.push_back(v);
        form_acc = '0;
        sat_seen = 1'b0;
      end
      default: begin
        // The unused operation code is dropped by the block.
      end
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_q16(input bit tame);
    logic [DATA_W-1:0] small_val;
    // Roughly +-8.0 in Q16.16, far from any clamp.
    small_val = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    if (tame) return small_val;
    case ($urandom_range(0, 7))
      0: return S32_MAX;
      1: return S32_MIN;
      2: return '0;
      3, 4: return small_val;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FORM_W-1:0] pick_rho(input bit tame);
    logic [FORM_W-1:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: return S64_MAX;
      1: return S64_MIN;
      2: return '0;
      3: return raw;
      default: return tame ? {{(FORM_W-46){raw[45]}}, raw[45:0]} : raw;
    endcase
  endfunction

  function automatic form_op_t random_op(input logic [1:0] code);
    form_op_t o;
    o.operation     = code;
    o.row_index     = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
    o.col_index     = IDX_W'($urandom_range(0, STORE_DEPTH - 1));
    o.sample_value  = pick_q16(1'b0);
    o.nominal_value = pick_q16(1'b0);
    o.matrix_value  = pick_q16(1'b0);
    o.rho_value     = pick_rho(1'b0);
    o.node_index    = NODE_W'($urandom_range(0, 65535));
    return o;
  endfunction

  task automatic push_state(input int r, input logic [DATA_W-1:0] s,
                            input logic [DATA_W-1:0] n);
    form_op_t o;
    o = random_op(OP_LOAD_STATE);
    o.row_index     = IDX_W'(r);
    o.sample_value  = s;
    o.nominal_value = n;
    op_queue.push_back(o);
  endtask

  task automatic push_matrix(input int r, input int c, input logic [DATA_W-1:0] m);
    form_op_t o;
    o = random_op(OP_LOAD_MATRIX);
    o.row_index    = IDX_W'(r);
    o.col_index    = IDX_W'(c);
    o.matrix_value = m;
    op_queue.push_back(o);
  endtask

  task automatic push_emit(input logic [FORM_W-1:0] rho);
    form_op_t o;
    o = random_op(OP_EMIT);
    o.rho_value = rho;
    op_queue.push_back(o);
  endtask

  task automatic report_mismatch(input string what, input verdict_t exp_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected node %h form %h upd %b sat %b, got node %h form %h upd %b sat %b",
               what, exp_v.node, exp_v.form, exp_v.upd, exp_v.sat,
               verdict_if.out_node_index, verdict_if.form_value,
               verdict_if.update_flag, verdict_if.saturated);
    end
  endtask

  // Sender: offers items from op_queue, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid <= 1'b0;
      op_bus   <= '0;
      near_end <= 1'b0;
      send_gap = 0;
    end else begin
      if (op_valid && op_if.ready) begin
        advance_form_model(op_bus);
      end
      if (!op_valid || op_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          op_valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          op_bus   <= op_queue.pop_front();
          op_valid <= 1'b1;
          if (!near_end && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          op_valid <= 1'b0;
        end
      end
      near_end <= (op_queue.size() < TAIL_ITEMS);
    end
  end

  // Receiver: random stall bursts plus one long hold that backs up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      stall_left = 0;
      sink_cycles = 0;
    end else begin
      sink_cycles++;
      if (sink_cycles == HOLD_START) begin
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !near_end && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni && verdict_if.valid && verdict_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with none pending", '0);
      end else begin
        exp_v = expected_verdicts.pop_front();
        if (verdict_if.out_node_index !== exp_v.node ||
            verdict_if.form_value !== exp_v.form ||
            verdict_if.update_flag !== exp_v.upd ||
            verdict_if.saturated !== exp_v.sat) begin
          report_mismatch("mismatch", exp_v);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int  rows[$];
    bit  tame;

    // Directed part. The empty-form emits come first, then every row of the
    // difference store is loaded so that no matrix load reads an unwritten row.
    push_emit('0);
    push_emit(64'd1);
    push_state(0, S32_MAX, S32_MIN);
    push_state(1, S32_MIN, S32_MAX);
    push_state(2, 32'h0001_0000, 32'h0000_0000);
    push_state(3, 32'hFFFE_8000, 32'h0000_4000);
    for (int k = 4; k < STORE_DEPTH; k++) push_state(k, $urandom(), $urandom());
    op_queue.push_back(random_op(OP_RESERVED));
    // Two full-scale terms: the first product clamps in each, while their sum stays in range.
    push_matrix(0, 0, S32_MAX);
    push_matrix(0, 0, S32_MAX);
    push_emit(S64_MAX);
    push_matrix(2, 2, 32'h0001_0000);
    push_matrix(2, 3, S32_MIN);
    push_emit(S64_MIN);
    push_matrix(1, 0, S32_MIN);
    push_matrix(7, 7, $urandom());
    push_emit(S64_MAX);
    push_matrix(3, 2, 32'hFFFF_0000);
    push_state(5, 32'h1234_5678, 32'h1234_5678);
    push_matrix(5, 6, S32_MAX);
    push_emit(pick_rho(1'b1));
    op_queue.push_back(random_op(OP_RESERVED));

    // Random part: mostly whole nodes, some loose noise items.
    while (op_queue.size() < TOTAL_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) op_queue.push_back(random_op(2'($urandom_range(0, 3))));
      end else begin
        // A tame node reloads the rows it uses with small values, so its form
        // stays clear of saturation and lands near rho.
        tame = ($urandom_range(0, 9) < 7);
        rows.delete();
        repeat ($urandom_range(tame ? 1 : 0, 4)) begin
          rows.push_back($urandom_range(0, STORE_DEPTH - 1));
          push_state(rows[$], pick_q16(tame), pick_q16(tame));
        end
        repeat ($urandom_range(1, 10)) begin
          if (tame) begin
            push_matrix(rows[$urandom_range(0, rows.size() - 1)],
                        rows[$urandom_range(0, rows.size() - 1)], pick_q16(1'b1));
          end else begin
            push_matrix($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, STORE_DEPTH - 1),
                        pick_q16(1'b0));
          end
        end
        push_emit(pick_rho(tame));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (op_queue.size() != 0 || op_valid || expected_verdicts.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
